// ----- rtl/jse_pkg.sv -----
`default_nettype none

package jse_pkg;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_SHORT,
        KIND_UNICODE
    } jse_kind_t;

    typedef struct packed {
        jse_kind_t  kind;
        logic [7:0] ch;
        logic       text_end;
    } jse_desc_t;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam int unsigned STEP_W = 3;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10) begin
            d = CH_ZERO + {4'd0, nib};
        end else begin
            d = CH_LOWER_A + {4'd0, nib} - 8'd10;
        end
        return d;
    endfunction

    function automatic logic [STEP_W-1:0] last_step(input jse_kind_t kind);
        logic [STEP_W-1:0] n;
        unique case (kind)
            KIND_PASS:    n = 3'd0;
            KIND_SHORT:   n = 3'd1;
            KIND_UNICODE: n = 3'd5;
            default:      n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/jse_front.sv -----
`default_nettype none

module jse_front
    import jse_pkg::*;
(
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic       s_tlast,   // in_text_end
    input  wire logic       q_full,
    output logic            push,
    output jse_desc_t       push_desc
);

    always_comb begin
        s_tready           = !q_full;
        push               = s_tvalid && !q_full;
        push_desc.text_end = s_tlast;
        push_desc.kind     = KIND_SHORT;
        push_desc.ch       = s_tdata;
        unique case (s_tdata)
            CH_QUOTE:     push_desc.ch = CH_QUOTE;
            CH_BACKSLASH: push_desc.ch = CH_BACKSLASH;
            CH_BS:        push_desc.ch = CH_B;
            CH_FF:        push_desc.ch = CH_F;
            CH_LF:        push_desc.ch = CH_N;
            CH_CR:        push_desc.ch = CH_R;
            CH_TAB:       push_desc.ch = CH_T;
            default: begin
                if (s_tdata < CH_SPACE) begin
                    push_desc.kind = KIND_UNICODE;
                end else begin
                    push_desc.kind = KIND_PASS;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/jse_queue.sv -----
`default_nettype none

module jse_queue
    import jse_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire jse_desc_t push_desc,
    output logic           full,
    input  wire logic      pop,
    output logic           head_valid,
    output jse_desc_t      head_desc
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    jse_desc_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        full        = (count_reg == CNT_W'(DEPTH));
        head_valid  = (count_reg != '0);
        head_desc   = mem[rd_ptr_reg];
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jse_back.sv -----
`default_nettype none

module jse_back
    import jse_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      head_valid,
    input  wire jse_desc_t head_desc,
    output logic           pop,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output logic [7:0]     m_tdata,   // out_byte
    output logic           m_tlast,   // run_last
    output logic           m_tuser    // out_text_end
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;
    logic              m_tuser_reg, m_tuser_next;
    logic              out_free;
    logic              fire;
    logic              is_last;
    logic [7:0]        cur_byte;

    always_comb begin
        out_free = !m_tvalid_reg || m_tready;
        fire     = head_valid && out_free;
        is_last  = (step_reg == last_step(head_desc.kind));
        pop      = fire && is_last;

        cur_byte = head_desc.ch;
        unique case (head_desc.kind)
            KIND_PASS: cur_byte = head_desc.ch;
            KIND_SHORT: begin
                cur_byte = (step_reg == 3'd0) ? CH_BACKSLASH : head_desc.ch;
            end
            KIND_UNICODE: begin
                unique case (step_reg)
                    3'd0:    cur_byte = CH_BACKSLASH;
                    3'd1:    cur_byte = CH_U;
                    3'd2:    cur_byte = CH_ZERO;
                    3'd3:    cur_byte = CH_ZERO;
                    3'd4:    cur_byte = hex_digit(head_desc.ch[7:4]);
                    default: cur_byte = hex_digit(head_desc.ch[3:0]);
                endcase
            end
            default: cur_byte = head_desc.ch;
        endcase

        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_free) begin
            m_tvalid_next = head_valid;
        end
        if (fire) begin
            step_next    = is_last ? '0 : step_reg + 1'b1;
            m_tdata_next = cur_byte;
            m_tlast_next = is_last;
            m_tuser_next = is_last && head_desc.text_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ----- rtl/json_string_escaper.sv -----
`default_nettype none

// Channel   Direction  Payload                                    Beat marker
// s_        in         tdata[7:0] in_byte, tlast in_text_end      one text byte
// m_        out        tdata[7:0] out_byte, tlast run_last,       one escaped byte
//                      tuser out_text_end
//
// The output side sends one beat per cycle unless stalled: an input byte gives one beat
// when it passes through, two for a short escape and six for the \u form, set by the
// output sequencer. A descriptor queue of QUEUE_DEPTH entries lets input beats be taken
// while an escape is being sent, so plain text flows at one byte per cycle unless stalled.
// Reset empties the queue and drops m_tvalid; s_tready falls only when the queue is full.

module json_string_escaper
    import jse_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic       s_tlast,   // in_text_end
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tlast,   // run_last
    output logic            m_tuser    // out_text_end
);

    logic      q_full;
    logic      push;
    jse_desc_t push_desc;
    logic      pop;
    logic      head_valid;
    jse_desc_t head_desc;

    jse_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    jse_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// ----- test/tb_json_string_escaper.sv -----
`timescale 1ns / 100ps

module tb_json_string_escaper;
    import jse_pkg::*;

    class escaped_text_scoreboard;
        typedef struct packed {
            logic [7:0] ch;
            logic       run_last;
            logic       text_end;
        } esc_beat_t;

        esc_beat_t   pending[$];
        int unsigned errors;
        int unsigned beats_seen;

        function logic [7:0] nibble_char(input logic [3:0] nib);
            if (nib < 4'd10) begin
                return 8'h30 + 8'(nib);
            end
            return 8'h61 + 8'(nib) - 8'd10;
        endfunction

        function void note_text_byte(input logic [7:0] b, input logic text_end);
            logic [7:0] seq [6];
            int         n;
            n = 2;
            seq[0] = CH_BACKSLASH;
            case (b)
                CH_QUOTE, CH_BACKSLASH: seq[1] = b;
                CH_BS:  seq[1] = CH_B;
                CH_FF:  seq[1] = CH_F;
                CH_LF:  seq[1] = CH_N;
                CH_CR:  seq[1] = CH_R;
                CH_TAB: seq[1] = CH_T;
                default: begin
                    if (b < CH_SPACE) begin
                        n = 6;
                        seq[1] = CH_U;
                        seq[2] = CH_ZERO;
                        seq[3] = CH_ZERO;
                        seq[4] = nibble_char(b[7:4]);
                        seq[5] = nibble_char(b[3:0]);
                    end else begin
                        n = 1;
                        seq[0] = b;
                    end
                end
            endcase
            for (int k = 0; k < n; k++) begin
                pending.push_back(esc_beat_t'{ch: seq[k], run_last: logic'(k == n - 1),
                                              text_end: logic'(k == n - 1) & text_end});
            end
        endfunction

        task report(input string msg);
            $display("ERROR: beat %0d: %s", beats_seen, msg);
            errors++;
        endtask

        task check_beat(input logic [7:0] ch, input logic run_last, input logic text_end);
            esc_beat_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat tdata=%02h tlast=%0b tuser=%0b",
                                 ch, run_last, text_end));
                beats_seen++;
                return;
            end
            want = pending.pop_front();
            if (ch !== want.ch) begin
                report($sformatf("tdata %02h, expected %02h", ch, want.ch));
            end
            if (run_last !== want.run_last) begin
                report($sformatf("tlast %0b, expected %0b", run_last, want.run_last));
            end
            if (text_end !== want.text_end) begin
                report($sformatf("tuser %0b, expected %0b", text_end, want.text_end));
            end
            beats_seen++;
        endtask
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    escaped_text_scoreboard sb = new();
    bit quiet_tail = 1'b0;

    logic [7:0] directed [25] = '{
        8'h00, 8'h01, 8'h07, 8'h0B, 8'h0E, 8'h10, 8'h1A, 8'h1F, CH_BS, CH_FF,
        CH_LF, CH_CR, CH_TAB, CH_QUOTE, CH_BACKSLASH, CH_SPACE, 8'h41, 8'h7E,
        8'h7F, 8'h80, 8'hAA, 8'h55, 8'hFF, 8'h2F, 8'h3A
    };

    json_string_escaper u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_text_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                sb.check_beat(m_tdata, m_tlast, m_tuser);
            end
        end
    end

    function logic [7:0] pick_text_byte();
        logic [7:0] escapes [7];
        int unsigned r;
        escapes = '{CH_QUOTE, CH_BACKSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB};
        r = $urandom_range(0, 9);
        if (r <= 3) begin
            return 8'($urandom_range(32, 126));
        end else if (r == 4) begin
            return escapes[$urandom_range(0, 6)];
        end else if (r <= 6) begin
            return 8'($urandom_range(0, 31));
        end else if (r == 7) begin
            return 8'($urandom_range(127, 255));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task send_text_byte(input logic [7:0] b, input logic text_end, input bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= text_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Holds the input off until every escaped byte owed so far has come out.
    task wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending.size() != 0);
    endtask

    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    initial begin
        int unsigned sent;
        int unsigned len;
        bit          noise;
        bit          paused;
        logic        text_end;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        aresetn  <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            send_text_byte(directed[i], logic'(i % 2), 1'b1);
        end
        wait_for_drain();

        // Random strings end with the text-end flag; a few noisy runs set it anywhere.
        sent = 0;
        paused = 1'b0;
        while (sent < 195) begin
            len = $urandom_range(1, 12);
            noise = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < len; k++) begin
                quiet_tail = (sent >= 160);
                text_end = noise ? logic'($urandom_range(0, 1)) : logic'(k == len - 1);
                send_text_byte(pick_text_byte(), text_end, !quiet_tail);
                sent++;
            end
            if (!paused && sent >= 100) begin
                paused = 1'b1;
                wait_for_drain();
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending.size() != 0);
        repeat (30) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
